FILE: design/jsma_pkg.sv
// shared types and constants for the joystick scale and moving average block
// no dependencies; imported by joystick_scale_moving_average_unit
package jsma_pkg;

  // raw sample and scaled value widths
  localparam int SAMPLE_W   = 16;
  localparam int SCALE_W    = 11;
  localparam int FULL_SCALE = 2047;

  // divider: numerator holds 2047 * 65535, quotient keeps one overflow bit
  localparam int NUM_W = SAMPLE_W + SCALE_W;
  localparam int QUO_W = SCALE_W + 1;
  localparam int CNT_W = $clog2(QUO_W);

  // channel numbering: pitch, roll, yaw, throttle
  localparam int NUM_CH = 4;
  localparam int CH_W   = 2;

  // register index: bits [2:1] pick the channel, bit 0 picks low or high
  localparam int CFG_IDX_W = 3;
  localparam logic CFG_SEL_LOW  = 1'b0;
  localparam logic CFG_SEL_HIGH = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SCALE_W-1:0]  scaled_t;
  typedef logic [CH_W-1:0]     chan_t;

  // calibration reset values per channel
  localparam sample_t CAL_LOW_RST  [NUM_CH] = '{16'd3621, 16'd4949, 16'd5177, 16'd4179};
  localparam sample_t CAL_HIGH_RST [NUM_CH] = '{16'd59969, 16'd62432, 16'd62918, 16'd60996};

endpackage

FILE: design/joystick_scale_moving_average_unit.sv
// joystick calibration scaling with per-channel moving average
// depends on jsma_pkg; holds the sequencer, bit-serial divider and history memory

// One transfer on the input carries both samples of one converter; one transfer on
// the output follows with the two windowed averages. Each channel is scaled with a
// shared restoring divider that resolves one quotient bit per cycle, and the same
// divider then forms sum / WINDOW_LEN. Per channel the steps are range prep,
// numerator load, the scaling division, history update and the averaging division,
// so each item runs four serial divisions. The input is not ready again until the
// result has been loaded into the output register, so one item is worked on at a
// time. A finished result waits in the output register while the next item is worked
// on; the block stalls only if a second result is ready before the first was taken.
// The history is reset by per-entry valid bits, so there is no clearing pass after
// reset.
module joystick_scale_moving_average_unit
  import jsma_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // first_sample[15:0], second_sample[31:16]
  input  logic                 in_tuser,   // converter
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // first_average[10:0], second_average[21:11]
  output logic                 out_tuser,  // which_pair
  output logic                 out_tlast,  // round_done
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata
);

  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int HIST_DEPTH = NUM_CH * WINDOW_LEN;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_MAX    = WINDOW_LEN * FULL_SCALE;
  localparam int SUM_W      = $clog2(SUM_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_SCALE,
    S_SUM,
    S_AVG,
    S_OUT
  } state_t;

  state_t               state_r;

  // captured item
  logic                 conv_r;
  logic                 sub_r;
  sample_t              smp_first_r;
  sample_t              smp_second_r;

  // calibration registers
  sample_t              cal_lo_r [NUM_CH];
  sample_t              cal_hi_r [NUM_CH];

  // window state
  logic [SUM_W-1:0]     sum_r [NUM_CH];
  logic [SLOT_W-1:0]    slot_r;
  logic [1:0]           rep_r;

  // range prep
  sample_t              dist_r;
  sample_t              span_r;

  // bit-serial divider
  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     quo_r;
  logic [CNT_W-1:0]     cnt_r;

  scaled_t              avg0_r;

  // output register
  logic                 out_tvalid_r;
  logic [23:0]          out_tdata_r;
  logic                 out_tuser_r;
  logic                 out_tlast_r;

  // history memory with valid bits
  scaled_t              hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_r;
  scaled_t              hist_rd_r;
  logic                 hist_rd_vld_r;

  chan_t                ch;
  sample_t              cur_smp;
  sample_t              cur_lo;
  sample_t              cur_hi;
  sample_t              dist_val;
  sample_t              span_val;
  logic [NUM_W-1:0]     scale_num;
  logic [ADDR_W-1:0]    hist_addr;
  logic                 div_ge;
  logic [NUM_W-1:0]     rem_step;
  logic [QUO_W-1:0]     quo_step;
  logic                 div_last;
  scaled_t              scaled_v;
  scaled_t              old_v;
  logic [SUM_W-1:0]     sum_new;
  logic [1:0]           rep_new;
  logic                 round_end;
  logic                 out_free;

  // channel and operands of the current half of the item
  always_comb begin
    ch        = {conv_r, sub_r};
    cur_smp   = sub_r ? smp_second_r : smp_first_r;
    cur_lo    = cal_lo_r[ch];
    cur_hi    = cal_hi_r[ch];
    span_val  = (cur_hi >= cur_lo) ? (cur_hi - cur_lo) : (cur_lo - cur_hi);
    dist_val  = (cur_smp >= cur_lo) ? (cur_smp - cur_lo) : (cur_lo - cur_smp);
    // 2047 * dist as a shift and subtract
    scale_num = {dist_r, {SCALE_W{1'b0}}} - NUM_W'(dist_r);
    hist_addr = ADDR_W'(int'(ch) * WINDOW_LEN + int'(slot_r));
  end

  // one restoring step; a zero divisor sets every bit and so saturates
  always_comb begin
    div_ge   = (rem_r >= dvs_r);
    rem_step = div_ge ? (rem_r - dvs_r) : rem_r;
    quo_step = {quo_r[QUO_W-2:0], div_ge};
    div_last = (cnt_r == CNT_W'(QUO_W - 1));
  end

  // saturate the scaled value and update the running sum
  always_comb begin
    scaled_v  = quo_r[QUO_W-1] ? scaled_t'(FULL_SCALE) : quo_r[SCALE_W-1:0];
    old_v     = hist_rd_vld_r ? hist_rd_r : '0;
    sum_new   = sum_r[ch] - SUM_W'(old_v) + SUM_W'(scaled_v);
    rep_new   = rep_r;
    rep_new[conv_r] = 1'b1;
    round_end = rep_new[0] & rep_new[1];
    out_free  = !out_tvalid_r || out_tready;
  end

  // history storage, read registered
  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      hist_rd_r <= hist_mem[hist_addr];
    end
    if (state_r == S_SUM) begin
      hist_mem[hist_addr] <= scaled_v;
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      slot_r        <= '0;
      rep_r         <= '0;
      hist_vld_r    <= '0;
      hist_rd_vld_r <= 1'b0;
      conv_r        <= 1'b0;
      sub_r         <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i]    <= '0;
        cal_lo_r[i] <= CAL_LOW_RST[i];
        cal_hi_r[i] <= CAL_HIGH_RST[i];
      end
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        if (cfg_index[0] == CFG_SEL_HIGH) begin
          cal_hi_r[cfg_index[2:1]] <= cfg_wdata;
        end else begin
          cal_lo_r[cfg_index[2:1]] <= cfg_wdata;
        end
      end

      // result taken downstream, unless the output step loads the next one
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            conv_r       <= in_tuser;
            smp_first_r  <= in_tdata[15:0];
            smp_second_r <= in_tdata[31:16];
            sub_r        <= 1'b0;
            state_r      <= S_PREP;
          end
        end
        S_PREP: begin
          dist_r        <= dist_val;
          span_r        <= span_val;
          hist_rd_vld_r <= hist_vld_r[hist_addr];
          state_r       <= S_LOAD;
        end
        S_LOAD: begin
          rem_r   <= scale_num;
          dvs_r   <= NUM_W'(span_r) << (QUO_W - 1);
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          rem_r <= rem_step;
          dvs_r <= dvs_r >> 1;
          quo_r <= quo_step;
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r[ch]             <= sum_new;
          hist_vld_r[hist_addr] <= 1'b1;
          rem_r                 <= NUM_W'(sum_new);
          dvs_r                 <= NUM_W'(WINDOW_LEN) << (QUO_W - 1);
          quo_r                 <= '0;
          cnt_r                 <= '0;
          state_r               <= S_AVG;
        end
        S_AVG: begin
          rem_r <= rem_step;
          dvs_r <= dvs_r >> 1;
          quo_r <= quo_step;
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            if (!sub_r) begin
              avg0_r  <= quo_step[SCALE_W-1:0];
              sub_r   <= 1'b1;
              state_r <= S_PREP;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {2'b00, quo_r[SCALE_W-1:0], avg0_r};
            out_tuser_r  <= conv_r;
            out_tlast_r  <= round_end;
            if (round_end) begin
              rep_r  <= '0;
              slot_r <= (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
            end else begin
              rep_r  <= rep_new;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // running sum of the active channel never exceeds a full window
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(sum_r[ch]) <= SUM_MAX)
    else $error("running sum beyond window maximum");

  // a finished round always clears both report flags
  a_rep_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !(rep_r[0] && rep_r[1]))
    else $error("both pair flags left set");

  // window slot stays inside the window
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(slot_r) < WINDOW_LEN)
    else $error("window slot out of range");

  // a transfer in starts work and drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready held after input transfer");

  // a new result appears only from the output step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");

endmodule

FILE: tb/joystick_scale_moving_average_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench for joystick_scale_moving_average_unit
// depends on jsma_pkg and the unit; predicts every averaged result and checks it in order

module joystick_scale_moving_average_unit_test;
  import jsma_pkg::*;

  localparam int AVG_DEPTH = 5;

  // converter codes carried in in_tuser and echoed in out_tuser
  typedef enum logic {
    CONV_PITCH_ROLL   = 1'b0,
    CONV_YAW_THROTTLE = 1'b1
  } conv_e;

  // calibration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_LOW, REG_PITCH_HIGH, REG_ROLL_LOW, REG_ROLL_HIGH,
    REG_YAW_LOW, REG_YAW_HIGH, REG_THROTTLE_LOW, REG_THROTTLE_HIGH
  } cal_reg_e;

  typedef struct packed {
    logic    pair;
    scaled_t first_avg;
    scaled_t second_avg;
    logic    round_done;
  } avg_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // first_sample[15:0], second_sample[31:16]
  logic                 in_tuser;   // converter
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // first_average[10:0], second_average[21:11]
  logic                 out_tuser;  // which_pair
  logic                 out_tlast;  // round_done
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_wdata;

  joystick_scale_moving_average_unit #(.WINDOW_LEN(AVG_DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state: calibration, per-channel window history and sums
  sample_t     cal_low  [NUM_CH];
  sample_t     cal_high [NUM_CH];
  scaled_t     win_hist [NUM_CH][AVG_DEPTH];
  int unsigned win_sum  [NUM_CH];
  int          win_slot;
  logic [1:0]  pair_seen;

  avg_result_t expected_avgs[$];
  bit          idle_on;
  int          mismatch_count;
  int          samples_sent;
  int          results_seen;
  int          rounds_seen;
  int          cal_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("timeout with %0d results still outstanding", expected_avgs.size());
    $display("== FAIL ==");
    $finish;
  end

  // scaled value of one raw sample for one channel
  function automatic scaled_t scale_raw(chan_t ch, sample_t raw);
    int unsigned lo, hi, span, offs, q;
    lo   = cal_low[ch];
    hi   = cal_high[ch];
    span = (hi >= lo) ? hi - lo : lo - hi;
    offs = (raw >= lo) ? raw - lo : lo - raw;
    if (span == 0) return scaled_t'(FULL_SCALE);
    q = (FULL_SCALE * offs) / span;
    return (q > FULL_SCALE) ? scaled_t'(FULL_SCALE) : scaled_t'(q);
  endfunction

  // replace the entry at the current slot and return the new average
  function automatic scaled_t push_history(chan_t ch, sample_t raw);
    scaled_t v;
    v = scale_raw(ch, raw);
    win_sum[ch] = win_sum[ch] - win_hist[ch][win_slot] + v;
    win_hist[ch][win_slot] = v;
    return scaled_t'(win_sum[ch] / AVG_DEPTH);
  endfunction

  function automatic avg_result_t predict_averages(conv_e conv, sample_t s1, sample_t s2);
    avg_result_t r;
    chan_t       base;
    base         = {conv, 1'b0};
    r.pair       = conv;
    r.first_avg  = push_history(base, s1);
    r.second_avg = push_history(chan_t'(base + 1), s2);
    r.round_done = 1'b0;
    pair_seen[conv] = 1'b1;
    // round complete: advance the shared slot
    if (pair_seen == 2'b11) begin
      win_slot     = (win_slot + 1) % AVG_DEPTH;
      pair_seen    = '0;
      r.round_done = 1'b1;
    end
    return r;
  endfunction

  // random sample biased toward the calibration points of the channel
  function automatic sample_t pick_sample(chan_t ch);
    int unsigned lo, hi;
    lo = cal_low[ch];
    hi = cal_high[ch];
    case ($urandom_range(0, 5))
      0: return sample_t'($urandom_range(hi, lo));
      1: return sample_t'(lo + $urandom_range(0, 8) - 4);
      2: return sample_t'(hi + $urandom_range(0, 8) - 4);
      3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one calibration register write, mirrored into the predictor
  task automatic write_reg(cal_reg_e idx, sample_t val);
    chan_t ch;
    ch = idx[2:1];
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx[0] == CFG_SEL_LOW) cal_low[ch] = val;
    else cal_high[ch] = val;
    cal_writes++;
  endtask

  task automatic write_channel_cal(chan_t ch, sample_t lo, sample_t hi);
    write_reg(cal_reg_e'({ch, CFG_SEL_LOW}), lo);
    write_reg(cal_reg_e'({ch, CFG_SEL_HIGH}), hi);
  endtask

  // one input transfer; valid stays high until the next call or a drain lowers it
  task automatic send_sample(conv_e conv, sample_t s1, sample_t s2);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= conv;
    in_tdata  <= {s2, s1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_avgs.push_back(predict_averages(conv, s1, s2));
    samples_sent++;
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
  endtask

  // receiver stalls in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_avgs
    avg_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pair       = out_tuser;
      got.first_avg  = out_tdata[10:0];
      got.second_avg = out_tdata[21:11];
      got.round_done = out_tlast;
      results_seen++;
      if (got.round_done === 1'b1) rounds_seen++;
      if (expected_avgs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result pair %0d first %0d second %0d round %0d",
                   $time, got.pair, got.first_avg, got.second_avg, got.round_done);
      end else begin
        want = expected_avgs.pop_front();
        if (got.pair !== want.pair || got.first_avg !== want.first_avg ||
            got.second_avg !== want.second_avg || got.round_done !== want.round_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch (exp/act) pair %0d/%0d first %0d/%0d %s",
                     $time, want.pair, got.pair, want.first_avg, got.first_avg,
                     $sformatf("second %0d/%0d round %0d/%0d", want.second_avg,
                               got.second_avg, want.round_done, got.round_done));
        end
      end
    end
  end

  // reset calibration: stick ends, samples outside the range, a repeated converter
  task automatic test_reset_calibration();
    send_sample(CONV_PITCH_ROLL,   16'd3621,  16'd4949);
    send_sample(CONV_YAW_THROTTLE, 16'd62918, 16'd60996);
    send_sample(CONV_PITCH_ROLL,   16'h0000,  16'hFFFF);
    send_sample(CONV_PITCH_ROLL,   16'd59969, 16'h0000);
    send_sample(CONV_YAW_THROTTLE, 16'h0000,  16'hFFFF);
    send_sample(CONV_YAW_THROTTLE, 16'hFFFF,  16'h0000);
    send_sample(CONV_YAW_THROTTLE, 16'd32768, 16'd32767);
    send_sample(CONV_PITCH_ROLL,   16'd32768, 16'd32767);
    drain_results();
  endtask

  // zero span, reversed ranges and full-scale calibration points
  task automatic test_special_calibration();
    write_reg(REG_PITCH_LOW,     16'd1000);
    write_reg(REG_PITCH_HIGH,    16'd1000);
    write_reg(REG_ROLL_LOW,      16'd60000);
    write_reg(REG_ROLL_HIGH,     16'd100);
    write_reg(REG_YAW_LOW,       16'h0000);
    write_reg(REG_YAW_HIGH,      16'hFFFF);
    write_reg(REG_THROTTLE_LOW,  16'hFFFF);
    write_reg(REG_THROTTLE_HIGH, 16'h0000);
    send_sample(CONV_PITCH_ROLL,   16'd1000,  16'd100);
    send_sample(CONV_YAW_THROTTLE, 16'h0000,  16'hFFFF);
    send_sample(CONV_PITCH_ROLL,   16'h0000,  16'd60000);
    send_sample(CONV_YAW_THROTTLE, 16'hFFFF,  16'h0000);
    send_sample(CONV_PITCH_ROLL,   16'hFFFF,  16'h0000);
    send_sample(CONV_YAW_THROTTLE, 16'd32767, 16'd32768);
    send_sample(CONV_PITCH_ROLL,   16'd999,   16'd30050);
    send_sample(CONV_YAW_THROTTLE, 16'h5555,  16'hAAAA);
    drain_results();
    // zero span at the top of the range, reversed full range
    write_reg(REG_PITCH_LOW,  16'hFFFF);
    write_reg(REG_PITCH_HIGH, 16'hFFFF);
    write_reg(REG_ROLL_LOW,   16'hFFFF);
    write_reg(REG_ROLL_HIGH,  16'h0000);
    send_sample(CONV_PITCH_ROLL,   16'hFFFF,  16'hFFFF);
    send_sample(CONV_PITCH_ROLL,   16'h0000,  16'h0000);
    send_sample(CONV_YAW_THROTTLE, 16'hAAAA,  16'h5555);
    send_sample(CONV_PITCH_ROLL,   16'h8000,  16'h7FFF);
    drain_results();
  endtask

  // fresh random calibration for every channel
  task automatic program_random_cal();
    sample_t     lo, hi;
    int unsigned step;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lo = sample_t'($urandom);
      case ($urandom_range(0, 5))
        0: hi = sample_t'($urandom);
        1: begin
          step = $urandom_range(1, 64);
          hi   = $urandom_range(0, 1) ? sample_t'(lo + step) : sample_t'(lo - step);
        end
        2: hi = lo;
        3: begin
          lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          hi = ~lo;
        end
        4: begin
          lo = sample_t'($urandom_range(2000, 8000));
          hi = sample_t'($urandom_range(56000, 63000));
        end
        default: begin
          hi = sample_t'($urandom_range(2000, 8000));
          lo = sample_t'($urandom_range(56000, 63000));
        end
      endcase
      write_channel_cal(chan_t'(ch), lo, hi);
    end
  endtask

  // mostly complete rounds with random content, now and then a repeated converter
  task automatic run_random_samples(int count);
    conv_e conv;
    chan_t base;
    conv = conv_e'($urandom_range(0, 1));
    repeat (count) begin
      base = {conv, 1'b0};
      send_sample(conv, pick_sample(base), pick_sample(chan_t'(base + 1)));
      if ($urandom_range(0, 7) != 0)
        conv = (conv == CONV_PITCH_ROLL) ? CONV_YAW_THROTTLE : CONV_PITCH_ROLL;
    end
  endtask

  task automatic test_random_calibrations();
    for (int phase = 0; phase < 7; phase++) begin
      program_random_cal();
      run_random_samples(160);
      drain_results();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    program_random_cal();
    run_random_samples(200);
    drain_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    idle_on    = 1'b1;
    win_slot   = 0;
    pair_seen  = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cal_low[ch]  = CAL_LOW_RST[ch];
      cal_high[ch] = CAL_HIGH_RST[ch];
      win_sum[ch]  = 0;
      for (int k = 0; k < AVG_DEPTH; k++) win_hist[ch][k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_calibration();
    test_special_calibration();
    test_random_calibrations();
    test_full_rate();

    // watch for stray results after the last one
    repeat (80) @(posedge clk);
    if (expected_avgs.size() != 0) begin
      mismatch_count++;
      $display("%0d predicted results never arrived", expected_avgs.size());
    end
    $display("sent %0d sample pairs, checked %0d averaged results (%0d closing a round)",
             samples_sent, results_seen, rounds_seen);
    $display("%0d calibration writes, %0d mismatches", cal_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: joystick_scale_moving_average_unit.f
design/jsma_pkg.sv
design/joystick_scale_moving_average_unit.sv
tb/joystick_scale_moving_average_unit_test.sv
